FILE: rtl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg: shared types and constants
// Record layout, parser state, phase codes and field encodings.
// ----------------------------------------------------------------------------
package mtp_pkg;

    localparam int unsigned VLQ_MAX_BYTES_DEF = 4;
    localparam int unsigned VLQ_CNT_W         = 4;   // holds up to 15

    typedef enum logic [3:0] {
        PH_DELTA       = 4'd0,
        PH_STATUS      = 4'd1,
        PH_META_TYPE   = 4'd2,
        PH_META_LEN    = 4'd3,
        PH_META_TEMPO  = 4'd4,
        PH_META_SKIP   = 4'd5,
        PH_SYSEX_LEN   = 4'd6,
        PH_SYSEX_SKIP  = 4'd7,
        PH_CHAN_D1     = 4'd8,
        PH_CHAN_D2     = 4'd9,
        PH_CHAN_D2_BAD = 4'd10,
        PH_SYS_SKIP    = 4'd11
    } phase_t;

    // record types
    localparam logic [1:0] REC_EVENT = 2'd0;
    localparam logic [1:0] REC_END   = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    // error codes
    localparam logic [3:0] ERR_DELTA    = 4'd0;
    localparam logic [3:0] ERR_MID_END  = 4'd1;
    localparam logic [3:0] ERR_RUNNING  = 4'd2;
    localparam logic [3:0] ERR_META     = 4'd3;
    localparam logic [3:0] ERR_TEMPO    = 4'd4;
    localparam logic [3:0] ERR_SYSEX    = 4'd5;
    localparam logic [3:0] ERR_CHAN_CUT = 4'd6;
    localparam logic [3:0] ERR_DATA     = 4'd7;
    localparam logic [3:0] ERR_SYSTEM   = 4'd8;

    // event kinds
    localparam logic [3:0] EV_MARKER  = 4'd0;
    localparam logic [3:0] EV_NOTEON  = 4'd1;
    localparam logic [3:0] EV_NOTEOFF = 4'd2;
    localparam logic [3:0] EV_CC      = 4'd3;
    localparam logic [3:0] EV_PROGRAM = 4'd4;
    localparam logic [3:0] EV_BEND    = 4'd5;
    localparam logic [3:0] EV_TOUCH   = 4'd6;
    localparam logic [3:0] EV_POLY    = 4'd7;
    localparam logic [3:0] EV_SYSEX   = 4'd8;
    localparam logic [3:0] EV_UNKNOWN = 4'd9;
    localparam logic [3:0] EV_TEMPO   = 4'd10;

    // status and meta bytes
    localparam logic [7:0] ST_CHAN_LAST = 8'hEF;
    localparam logic [7:0] ST_REALTIME  = 8'hF8;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_MTC_QF    = 8'hF1;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_TOUCH     = 4'hD;

    typedef struct packed {
        logic [1:0]  record_type;
        logic [3:0]  error_code;
        logic [3:0]  event_kind;
        logic [63:0] tick;
        logic [3:0]  channel;
        logic [7:0]  status_byte;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [27:0] event_value;
        logic        last_of_step;
    } rec_t;

    typedef struct packed {
        phase_t                 phase;
        logic [31:0]            bytes_left;
        logic [63:0]            tick_count;
        logic [7:0]             running_status;
        logic [27:0]            vlq_accum;
        logic [VLQ_CNT_W-1:0]   vlq_bytes;
        logic [7:0]             current_status;
        logic [7:0]             meta_kind;
        logic [6:0]             held_data;
        logic [27:0]            skip_left;
        logic [23:0]            tempo_accum;
        logic                   halted;
    } state_t;

    function automatic logic [3:0] chan_kind(input logic [2:0] hi);
        logic [3:0] k;
        case (hi)
            3'd0:    k = EV_NOTEOFF;
            3'd1:    k = EV_NOTEON;
            3'd2:    k = EV_POLY;
            3'd3:    k = EV_CC;
            3'd4:    k = EV_PROGRAM;
            3'd5:    k = EV_TOUCH;
            3'd6:    k = EV_BEND;
            default: k = EV_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic rec_t mk_event(input logic [3:0] kind, input logic [63:0] tk,
                                      input logic [7:0] st, input logic [27:0] val);
        rec_t r;
        r = '0;
        r.record_type = REC_EVENT;
        r.event_kind  = kind;
        r.tick        = tk;
        r.status_byte = st;
        r.event_value = val;
        return r;
    endfunction

    function automatic rec_t mk_chan(input logic [63:0] tk, input logic [7:0] st,
                                     input logic [6:0] d1, input logic [6:0] d2);
        rec_t r;
        r = '0;
        r.record_type = REC_EVENT;
        r.event_kind  = chan_kind(st[6:4]);
        r.tick        = tk;
        r.channel     = st[3:0];
        r.status_byte = st;
        r.first_data  = d1;
        r.second_data = d2;
        return r;
    endfunction

endpackage

FILE: rtl/mtp_if.sv
// ----------------------------------------------------------------------------
// mtp interfaces: byte, record and config channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface mtp_byte_if;
    logic       valid;
    logic       ready;
    logic       track_start;
    logic [7:0] data_byte;
    modport source (output valid, track_start, data_byte, input ready);
    modport sink   (input valid, track_start, data_byte, output ready);
endinterface

interface mtp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_type;
    logic [3:0]  error_code;
    logic [3:0]  event_kind;
    logic [63:0] tick;
    logic [3:0]  channel;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [27:0] event_value;
    logic        last_of_step;
    modport source (output valid, record_type, error_code, event_kind, tick, channel,
                    status_byte, first_data, second_data, event_value, last_of_step,
                    input ready);
    modport sink   (input valid, record_type, error_code, event_kind, tick, channel,
                    status_byte, first_data, second_data, event_value, last_of_step,
                    output ready);
endinterface

interface mtp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/mtp_step.sv
// ----------------------------------------------------------------------------
// mtp_step: per-byte parse logic
// Next parser state and up to two result records for one accepted beat.
// ----------------------------------------------------------------------------
module mtp_step
    import mtp_pkg::*;
#(
    parameter int unsigned VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEF
)
(
    input  state_t      cur,
    input  logic [31:0] track_length,
    input  logic        track_start,
    input  logic [7:0]  data_byte,
    output state_t      nxt,
    output rec_t        rec0,
    output logic        rec0_valid,
    output rec_t        rec1,
    output logic        rec1_valid
);

    localparam logic [VLQ_CNT_W-1:0] VLQ_LIMIT = VLQ_CNT_W'(VLQ_MAX_BYTES);

    state_t                 n;
    rec_t                   ev;
    rec_t                   rec_end;
    rec_t                   rec_err;
    logic                   ev_v;
    logic                   end_v;
    logic                   err_v;
    logic [3:0]             ecode;
    logic                   proc;
    logic                   fin;
    logic                   two;
    logic                   hasf;
    logic [7:0]             s;
    logic [31:0]            left;
    logic [27:0]            acc_n;
    logic [VLQ_CNT_W-1:0]   cnt_n;
    logic                   vbad;
    logic [1:0]             nsys;
    logic [64:0]            tsum;

    always_comb
    begin
        n     = cur;
        ev    = '0;
        ev_v  = 1'b0;
        end_v = 1'b0;
        err_v = 1'b0;
        ecode = ERR_DELTA;
        fin   = 1'b0;
        two   = 1'b0;
        hasf  = 1'b0;
        s     = data_byte;
        nsys  = 2'd0;
        tsum  = '0;
        proc  = 1'b1;

        if (track_start)
        begin
            n.tick_count     = '0;
            n.running_status = '0;
            n.bytes_left     = track_length;
            n.phase          = PH_DELTA;
            n.vlq_accum      = '0;
            n.vlq_bytes      = '0;
            n.halted         = 1'b0;
            if (track_length == 32'd0)
            begin
                end_v    = 1'b1;
                n.halted = 1'b1;
                proc     = 1'b0;
            end
        end
        if (n.halted || n.bytes_left == 32'd0)
            proc = 1'b0;

        left  = n.bytes_left - 32'd1;
        acc_n = {n.vlq_accum[20:0], data_byte[6:0]};
        cnt_n = n.vlq_bytes + 1'b1;
        vbad  = data_byte[7] && (cnt_n >= VLQ_LIMIT || left == 32'd0);

        if (proc)
        begin
            n.bytes_left = left;
            unique case (n.phase)
                PH_STATUS:
                begin
                    if (data_byte[7])
                    begin
                        if (data_byte <= ST_CHAN_LAST)
                            n.running_status = data_byte;
                        else if (data_byte < ST_REALTIME)
                            n.running_status = '0;
                    end
                    else if (n.running_status == 8'd0)
                    begin
                        err_v = 1'b1;
                        ecode = ERR_RUNNING;
                    end
                    else
                    begin
                        s    = n.running_status;
                        hasf = 1'b1;
                    end
                    if (!err_v)
                    begin
                        n.current_status = s;
                        two = s[7:4] != HI_PROGRAM && s[7:4] != HI_TOUCH;
                        if (s == ST_META)
                        begin
                            if (left == 32'd0)
                            begin
                                err_v = 1'b1;
                                ecode = ERR_META;
                            end
                            else
                                n.phase = PH_META_TYPE;
                        end
                        else if (s == ST_SYSEX || s == ST_SYSEX_ESC)
                        begin
                            if (left == 32'd0)
                            begin
                                err_v = 1'b1;
                                ecode = ERR_SYSEX;
                            end
                            else
                            begin
                                n.vlq_accum = '0;
                                n.vlq_bytes = '0;
                                n.phase     = PH_SYSEX_LEN;
                            end
                        end
                        else if (s[7] && s <= ST_CHAN_LAST)
                        begin
                            if (hasf)
                            begin
                                n.held_data = data_byte[6:0];
                                if (two)
                                begin
                                    if (left == 32'd0)
                                    begin
                                        err_v = 1'b1;
                                        ecode = ERR_CHAN_CUT;
                                    end
                                    else
                                        n.phase = PH_CHAN_D2;
                                end
                                else
                                begin
                                    ev   = mk_chan(n.tick_count, s, data_byte[6:0], 7'd0);
                                    ev_v = 1'b1;
                                    fin  = 1'b1;
                                end
                            end
                            else if (left == 32'd0)
                            begin
                                err_v = 1'b1;
                                ecode = ERR_CHAN_CUT;
                            end
                            else
                                n.phase = PH_CHAN_D1;
                        end
                        else
                        begin
                            if (s == ST_MTC_QF || s == ST_SONG_SEL)
                                nsys = 2'd1;
                            else if (s == ST_SONG_POS)
                                nsys = 2'd2;
                            if ({30'd0, nsys} > left)
                            begin
                                err_v = 1'b1;
                                ecode = ERR_SYSTEM;
                            end
                            else if (nsys == 2'd0)
                                fin = 1'b1;
                            else
                            begin
                                n.skip_left = {26'd0, nsys};
                                n.phase     = PH_SYS_SKIP;
                            end
                        end
                    end
                end
                PH_META_TYPE:
                begin
                    n.meta_kind = data_byte;
                    if (left == 32'd0)
                    begin
                        err_v = 1'b1;
                        ecode = ERR_META;
                    end
                    else
                    begin
                        n.vlq_accum = '0;
                        n.vlq_bytes = '0;
                        n.phase     = PH_META_LEN;
                    end
                end
                PH_META_LEN:
                begin
                    n.vlq_accum = acc_n;
                    if (data_byte[7])
                        n.vlq_bytes = cnt_n;
                    if (vbad)
                    begin
                        err_v = 1'b1;
                        ecode = ERR_META;
                    end
                    else if (!data_byte[7])
                    begin
                        if ({4'd0, acc_n} > left)
                        begin
                            err_v = 1'b1;
                            ecode = ERR_META;
                        end
                        else if (n.meta_kind == META_TEMPO && acc_n == 28'd3)
                        begin
                            n.tempo_accum = '0;
                            n.skip_left   = 28'd3;
                            n.phase       = PH_META_TEMPO;
                        end
                        else if (acc_n == 28'd0)
                        begin
                            ev_v = n.meta_kind != META_EOT;
                            ev   = mk_event(EV_MARKER, n.tick_count, 8'd0, 28'd0);
                            fin  = 1'b1;
                        end
                        else
                        begin
                            n.skip_left = acc_n;
                            n.phase     = PH_META_SKIP;
                        end
                    end
                end
                PH_META_TEMPO:
                begin
                    n.tempo_accum = {n.tempo_accum[15:0], data_byte};
                    n.skip_left   = n.skip_left - 28'd1;
                    if (n.skip_left == 28'd0)
                    begin
                        ev_v = 1'b1;
                        fin  = 1'b1;
                        if (n.tempo_accum != 24'd0)
                            ev = mk_event(EV_TEMPO, n.tick_count, 8'd0,
                                          {4'd0, n.tempo_accum});
                        else
                            ev = mk_event(EV_MARKER, n.tick_count, 8'd0, 28'd0);
                    end
                end
                PH_META_SKIP:
                begin
                    n.skip_left = n.skip_left - 28'd1;
                    if (n.skip_left == 28'd0)
                    begin
                        ev_v = n.meta_kind != META_EOT;
                        ev   = mk_event(EV_MARKER, n.tick_count, 8'd0, 28'd0);
                        fin  = 1'b1;
                    end
                end
                PH_SYSEX_LEN:
                begin
                    n.vlq_accum = acc_n;
                    if (data_byte[7])
                        n.vlq_bytes = cnt_n;
                    if (vbad)
                    begin
                        err_v = 1'b1;
                        ecode = ERR_SYSEX;
                    end
                    else if (!data_byte[7])
                    begin
                        if ({4'd0, acc_n} > left)
                        begin
                            err_v = 1'b1;
                            ecode = ERR_SYSEX;
                        end
                        else if (acc_n == 28'd0)
                        begin
                            ev_v = 1'b1;
                            ev   = mk_event(EV_SYSEX, n.tick_count, n.current_status, 28'd0);
                            fin  = 1'b1;
                        end
                        else
                        begin
                            n.skip_left = acc_n;
                            n.phase     = PH_SYSEX_SKIP;
                        end
                    end
                end
                PH_SYSEX_SKIP:
                begin
                    n.skip_left = n.skip_left - 28'd1;
                    if (n.skip_left == 28'd0)
                    begin
                        ev_v = 1'b1;
                        ev   = mk_event(EV_SYSEX, n.tick_count, n.current_status,
                                        n.vlq_accum);
                        fin  = 1'b1;
                    end
                end
                PH_CHAN_D1:
                begin
                    n.held_data = data_byte[6:0];
                    two = n.current_status[7:4] != HI_PROGRAM
                          && n.current_status[7:4] != HI_TOUCH;
                    if (two)
                    begin
                        if (left == 32'd0)
                        begin
                            err_v = 1'b1;
                            ecode = ERR_CHAN_CUT;
                        end
                        else
                            n.phase = data_byte[7] ? PH_CHAN_D2_BAD : PH_CHAN_D2;
                    end
                    else if (data_byte[7])
                    begin
                        err_v = 1'b1;
                        ecode = ERR_DATA;
                    end
                    else
                    begin
                        ev_v = 1'b1;
                        ev   = mk_chan(n.tick_count, n.current_status, data_byte[6:0], 7'd0);
                        fin  = 1'b1;
                    end
                end
                PH_CHAN_D2:
                begin
                    if (data_byte[7])
                    begin
                        err_v = 1'b1;
                        ecode = ERR_DATA;
                    end
                    else
                    begin
                        ev_v = 1'b1;
                        ev   = mk_chan(n.tick_count, n.current_status, n.held_data,
                                       data_byte[6:0]);
                        fin  = 1'b1;
                    end
                end
                PH_CHAN_D2_BAD:
                begin
                    err_v = 1'b1;
                    ecode = ERR_DATA;
                end
                PH_SYS_SKIP:
                begin
                    n.skip_left = n.skip_left - 28'd1;
                    if (n.skip_left == 28'd0)
                        fin = 1'b1;
                end
                default:
                begin
                    // delta time
                    n.vlq_accum = acc_n;
                    if (data_byte[7])
                        n.vlq_bytes = cnt_n;
                    if (vbad)
                    begin
                        err_v = 1'b1;
                        ecode = ERR_DELTA;
                    end
                    else if (data_byte[7])
                        n.phase = PH_DELTA;
                    else
                    begin
                        tsum = {1'b0, n.tick_count} + {37'd0, acc_n};
                        if (tsum[64])
                        begin
                            err_v = 1'b1;
                            ecode = ERR_DELTA;
                        end
                        else
                        begin
                            n.tick_count = tsum[63:0];
                            n.vlq_accum  = '0;
                            n.vlq_bytes  = '0;
                            if (left == 32'd0)
                            begin
                                err_v = 1'b1;
                                ecode = ERR_MID_END;
                            end
                            else
                                n.phase = PH_STATUS;
                        end
                    end
                end
            endcase

            if (fin)
            begin
                n.phase     = PH_DELTA;
                n.vlq_accum = '0;
                n.vlq_bytes = '0;
                if (left == 32'd0)
                begin
                    end_v    = 1'b1;
                    n.halted = 1'b1;
                end
            end
            if (err_v)
                n.halted = 1'b1;
        end

        rec_end              = '0;
        rec_end.record_type  = REC_END;
        rec_end.tick         = n.tick_count;
        rec_end.last_of_step = 1'b1;

        rec_err              = '0;
        rec_err.record_type  = REC_ERROR;
        rec_err.error_code   = ecode;
        rec_err.last_of_step = 1'b1;

        nxt        = n;
        rec1       = rec_end;
        rec1_valid = 1'b0;
        if (ev_v)
        begin
            rec0              = ev;
            rec0.last_of_step = !end_v;
            rec0_valid        = 1'b1;
            rec1_valid        = end_v;
        end
        else if (end_v)
        begin
            rec0       = rec_end;
            rec0_valid = 1'b1;
        end
        else
        begin
            rec0       = rec_err;
            rec0_valid = err_v;
        end
    end

endmodule

FILE: rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser: track chunk byte parser
// Decodes one track chunk byte per beat into event, track-end and error records.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Beat                          Notes
//  byte_ch   in    track_start, data_byte        one chunk byte per beat
//  rec_ch    out   one record (event/end/error)  at most two records per byte
//  cfg       in    track_length (32 bits)        write only while idle
//
//  One byte is taken per cycle unless byte_ch is stalled. Parse logic sits
//  between the parser state register and the record register, so a record
//  appears in the cycle after its byte. A byte that yields two records
//  (event then track end) holds byte_ch while the second record drains.
//  rst_n clears all parser state, the stored length and the record buffer.
//  Back pressure on rec_ch stalls byte_ch once the record register is full.
//
module midi_track_event_parser
    import mtp_pkg::*;
#(
    parameter int unsigned VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    mtp_byte_if.sink    byte_ch,
    mtp_rec_if.source   rec_ch,
    mtp_cfg_if.sink     cfg
);

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] track_length_reg;
    rec_t        out_reg;
    logic        out_valid_reg;
    rec_t        pend_reg;
    logic        pend_valid_reg;

    rec_t        rec0;
    rec_t        rec1;
    logic        rec0_valid;
    logic        rec1_valid;
    logic        in_fire;
    logic        out_fire;

    // config: always ready, writes land directly
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            track_length_reg <= '0;
        else if (cfg.valid)
            track_length_reg <= cfg.data;
    end

    // next byte accepted when the record register is empty or draining
    // and no second record is waiting behind it
    assign byte_ch.ready = !out_valid_reg || (rec_ch.ready && !pend_valid_reg);
    assign in_fire       = byte_ch.valid && byte_ch.ready;
    assign out_fire      = out_valid_reg && rec_ch.ready;

    mtp_step #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
    ) u_step (
        .cur          (state_reg),
        .track_length (track_length_reg),
        .track_start  (byte_ch.track_start),
        .data_byte    (byte_ch.data_byte),
        .nxt          (state_next),
        .rec0         (rec0),
        .rec0_valid   (rec0_valid),
        .rec1         (rec1),
        .rec1_valid   (rec1_valid)
    );

    // all-zero state is phase PH_DELTA with nothing counted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_fire)
            state_reg <= state_next;
    end

    // two-deep record buffer: out_reg drives the port, pend_reg holds a
    // trailing track-end record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg  <= rec0_valid;
            pend_valid_reg <= rec1_valid;
        end
        else if (out_fire)
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg  <= rec0;
            pend_reg <= rec1;
        end
        else if (out_fire)
            out_reg <= pend_reg;
    end

    assign rec_ch.valid        = out_valid_reg;
    assign rec_ch.record_type  = out_reg.record_type;
    assign rec_ch.error_code   = out_reg.error_code;
    assign rec_ch.event_kind   = out_reg.event_kind;
    assign rec_ch.tick         = out_reg.tick;
    assign rec_ch.channel      = out_reg.channel;
    assign rec_ch.status_byte  = out_reg.status_byte;
    assign rec_ch.first_data   = out_reg.first_data;
    assign rec_ch.second_data  = out_reg.second_data;
    assign rec_ch.event_value  = out_reg.event_value;
    assign rec_ch.last_of_step = out_reg.last_of_step;

endmodule

FILE: rtl/mtp_checker.sv
// ----------------------------------------------------------------------------
// mtp_checker: port-level assertions
// Checks record output behavior seen at the parser's ports.
// ----------------------------------------------------------------------------
module mtp_checker
    import mtp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  record_type,
    input logic [3:0]  error_code,
    input logic [63:0] tick,
    input logic        last_of_step
);

    // stalled record stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_type) && $stable(tick))
        else $error("record changed while stalled");

    // end and error records always close their byte's output
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_type != REC_EVENT |-> last_of_step)
        else $error("terminal record not last of step");

    // error records carry zero tick and a producible code
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_type == REC_ERROR
        |-> tick == 64'd0 && error_code <= ERR_SYSTEM && error_code != ERR_TEMPO)
        else $error("bad error record");

    // an event that is not last is followed directly by its track end,
    // during which no byte is taken
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && record_type == REC_EVENT && !last_of_step
        |-> !(in_valid && in_ready) ##1 out_valid && record_type == REC_END)
        else $error("event pair broken");

endmodule

bind midi_track_event_parser mtp_checker u_mtp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_ch.valid),
    .in_ready     (byte_ch.ready),
    .out_valid    (rec_ch.valid),
    .out_ready    (rec_ch.ready),
    .record_type  (rec_ch.record_type),
    .error_code   (rec_ch.error_code),
    .tick         (rec_ch.tick),
    .last_of_step (rec_ch.last_of_step)
);
